>>> sv/csgl_pkg.sv
// csgl_pkg: shared constants, codes and control types of the chained sg list builder
// no dependencies; compiled first
package csgl_pkg;

    localparam int PAGE_BYTES_DEF = 4096;
    localparam int BLOCK_ENTRIES = 8;
    localparam int CHAIN_LEN = 128;

    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    // n/7 as (n * RECIP7) >> RECIP7_SHIFT, exact for 16-bit n
    localparam logic [16:0] RECIP7 = 17'd74899;
    localparam int RECIP7_SHIFT = 19;

    localparam logic [1:0] KIND_CHAIN = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OFFSET = 2'd1;
    localparam logic [1:0] ST_SMALL = 2'd2;

    localparam logic [2:0] REG_FIRST_OFFSET = 3'd0;
    localparam logic [2:0] REG_TOTAL_BYTES = 3'd1;
    localparam logic [2:0] REG_PAGE_COUNT = 3'd2;
    localparam logic [2:0] REG_LIST_BASE = 3'd3;
    localparam logic [2:0] REG_LIST_BYTES = 3'd4;

    typedef struct packed {
        logic take;
        logic proc;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic has_results;
        logic drain_last;
    } stat_t;

endpackage

>>> sv/csgl_page_if.sv
// csgl_page_if: valid/ready channel carrying one page address per transaction
// no dependencies
interface csgl_page_if;
    logic        valid;
    logic        ready;
    logic [63:0] page_addr;

    modport source (output valid, output page_addr, input ready);
    modport sink (input valid, input page_addr, output ready);
endinterface

>>> sv/csgl_entry_if.sv
// csgl_entry_if: valid/ready channel carrying one list entry per transaction
// no dependencies
interface csgl_entry_if;
    logic        valid;
    logic        ready;
    logic [16:0] entry_pos;
    logic [63:0] entry_addr;
    logic [31:0] entry_len;
    logic [1:0]  entry_kind;
    logic [1:0]  status;
    logic        last_of_run;

    modport source (output valid, output entry_pos, output entry_addr, output entry_len,
                    output entry_kind, output status, output last_of_run, input ready);
    modport sink (input valid, input entry_pos, input entry_addr, input entry_len,
                  input entry_kind, input status, input last_of_run, output ready);
endinterface

>>> sv/chained_sg_list_builder.sv
// Chained scatter-gather list builder: takes one page address per transaction and
// returns the list entries it settles. A page is taken in one cycle and processed in
// the next; the entries a page settles then leave one per cycle while the sink is
// ready, each by a single read of the held entry store into the output register.
// Intake stays closed until the last entry of a page is taken. Configuration goes
// through the APB port at byte address 8*i; any write to one of the five registers
// restarts the run. The page size parameter must be a power of two.
module chained_sg_list_builder #(
    parameter int PAGE_BYTES = csgl_pkg::PAGE_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [csgl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [csgl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [csgl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    csgl_page_if.sink                       page_in,
    csgl_entry_if.source                    entry_out
);

    csgl_pkg::cmd_t  cmd;
    csgl_pkg::stat_t stat;

    assign pready = 1'b1;

    csgl_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (page_in.valid),
        .in_ready  (page_in.ready),
        .out_valid (entry_out.valid),
        .out_ready (entry_out.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    csgl_datapath #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .page_addr   (page_in.page_addr),
        .cmd         (cmd),
        .stat        (stat),
        .entry_pos   (entry_out.entry_pos),
        .entry_addr  (entry_out.entry_addr),
        .entry_len   (entry_out.entry_len),
        .entry_kind  (entry_out.entry_kind),
        .status      (entry_out.status),
        .last_of_run (entry_out.last_of_run)
    );

endmodule

>>> sv/csgl_datapath.sv
// csgl_datapath: config registers, run state, held entry store and output register
// depends on csgl_pkg
module csgl_datapath #(
    parameter int PAGE_BYTES = csgl_pkg::PAGE_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [csgl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [csgl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [csgl_pkg::CFG_DATA_W-1:0] prdata,
    input  logic [63:0]                     page_addr,
    input  csgl_pkg::cmd_t                  cmd,
    output csgl_pkg::stat_t                 stat,
    output logic [16:0]                     entry_pos,
    output logic [63:0]                     entry_addr,
    output logic [31:0]                     entry_len,
    output logic [1:0]                      entry_kind,
    output logic [1:0]                      status,
    output logic                            last_of_run
);

    // page size must be a power of two; the block itself does not enforce it
    localparam logic [31:0] PageBytes32 = 32'(PAGE_BYTES);
    localparam logic [31:0] PageMask = ~(PageBytes32 - 32'd1);

    logic [13:0] first_offset_reg;
    logic [31:0] total_bytes_reg;
    logic [15:0] page_count_reg;
    logic [63:0] list_base_reg;
    logic [31:0] list_bytes_reg;

    logic [15:0] pages_taken_reg;
    logic [3:0]  slot_in_block_reg;
    logic [15:0] blocks_done_reg;
    logic [31:0] bytes_left_reg;
    logic [63:0] next_contig_reg;
    logic        have_fragment_reg;
    logic        error_latched_reg;

    logic [63:0] page_reg;
    logic [31:0] cur_len_reg;

    logic [63:0] held_addr [16];
    logic [31:0] held_len [16];
    logic [1:0]  held_kind [16];

    // drain plan
    logic        p_single_reg;
    logic [1:0]  p_skind_reg;
    logic [1:0]  p_sstatus_reg;
    logic        p_prev_reg;
    logic [15:0] p_pb_reg;
    logic        p_tail_reg;
    logic [15:0] p_tb_reg;
    logic [2:0]  p_k_reg;
    logic [3:0]  drain_idx_reg;
    logic        out_last_reg;

    logic [16:0] pos_reg;
    logic [63:0] addr_reg;
    logic [31:0] len_reg;
    logic [1:0]  kind_reg;
    logic [1:0]  status_reg;
    logic        lor_reg;

    logic        cfg_we;
    logic        cfg_hit;
    logic [32:0] recip_prod;
    logic [13:0] div7;
    logic [20:0] need_bytes;
    logic        chk, off_err, small_err, zero_pc, start, run;
    logic [13:0] off;
    logic [3:0]  slot_e;
    logic [15:0] bd_e;
    logic [31:0] bl_e;
    logic        have_e;
    logic [15:0] pages_e;
    logic        need_chain;
    logic [15:0] bd_next;
    logic [3:0]  slot_c;
    logic [31:0] room;
    logic [31:0] size;
    logic [63:0] daddr;
    logic        merge;
    logic [3:0]  merge_idx;
    logic        prev;
    logic [3:0]  slot_next;
    logic [15:0] pages_next;
    logic        is_last;
    logic [15:0] tb_next;
    logic [2:0]  k_next;
    logic [63:0] chain_addr;

    logic [4:0]  total;
    logic [2:0]  t_idx;
    logic [3:0]  rd_idx;
    logic [16:0] e_pos;
    logic [63:0] e_addr;
    logic [31:0] e_len;
    logic [1:0]  e_kind;
    logic [1:0]  e_status;
    logic        e_lor;

    assign cfg_we = psel && penable && pwrite;
    assign cfg_hit = cfg_we && (paddr[5:3] <= csgl_pkg::REG_LIST_BYTES);

    always_comb
    begin
        case (paddr[5:3])
            csgl_pkg::REG_FIRST_OFFSET: prdata = {50'd0, first_offset_reg};
            csgl_pkg::REG_TOTAL_BYTES:  prdata = {32'd0, total_bytes_reg};
            csgl_pkg::REG_PAGE_COUNT:   prdata = {48'd0, page_count_reg};
            csgl_pkg::REG_LIST_BASE:    prdata = list_base_reg;
            csgl_pkg::REG_LIST_BYTES:   prdata = {32'd0, list_bytes_reg};
            default:                    prdata = '0;
        endcase
    end

    always_comb
    begin
        recip_prod = {17'd0, page_count_reg} * {16'd0, csgl_pkg::RECIP7};
        div7 = recip_prod[csgl_pkg::RECIP7_SHIFT +: 14];
        need_bytes = {({1'b0, page_count_reg} + {3'd0, div7} + 17'd1), 4'd0};

        chk = (pages_taken_reg == 16'd0);
        off_err = chk && ({18'd0, first_offset_reg} > PageBytes32);
        small_err = chk && !off_err && ({11'd0, need_bytes} > (list_bytes_reg & PageMask));
        zero_pc = chk && !off_err && !small_err && (page_count_reg == 16'd0);
        start = chk && !off_err && !small_err && !zero_pc;
        run = !error_latched_reg && !off_err && !small_err && !zero_pc;

        off = start ? first_offset_reg : 14'd0;
        slot_e = start ? 4'd0 : slot_in_block_reg;
        bd_e = start ? 16'd0 : blocks_done_reg;
        bl_e = start ? total_bytes_reg : bytes_left_reg;
        have_e = start ? 1'b0 : have_fragment_reg;
        pages_e = start ? 16'd0 : pages_taken_reg;

        need_chain = (slot_e == 4'd0) || (slot_e >= 4'd8);
        bd_next = (slot_e >= 4'd8) ? bd_e + 16'd1 : bd_e;
        slot_c = need_chain ? 4'd1 : slot_e;
        chain_addr = list_base_reg + {41'd0, bd_next + 16'd1, 7'd0};

        room = PageBytes32 - {18'd0, off};
        size = (bl_e < room) ? bl_e : room;
        daddr = page_reg + {50'd0, off};

        merge = have_e && (daddr == next_contig_reg);
        // merge right after a chain entry lands in the last slot of the previous block
        merge_idx = (slot_c == 4'd1) ? {~bd_next[0], 3'd7}
                                     : {bd_next[0], slot_c[2:0] - 3'd1};
        prev = !merge && (slot_c == 4'd1) && (bd_next != 16'd0);
        slot_next = merge ? slot_c : slot_c + 4'd1;
        pages_next = pages_e + 16'd1;
        is_last = (pages_next >= page_count_reg);

        if ((slot_next == 4'd1) && (bd_next != 16'd0))
        begin
            tb_next = bd_next - 16'd1;
            k_next = 3'd7;
        end
        else
        begin
            tb_next = bd_next;
            k_next = 3'(slot_next - 4'd1);
        end
    end

    assign stat.has_results = !error_latched_reg &&
                              (off_err || small_err || zero_pc || prev || is_last);
    assign stat.drain_last = out_last_reg;

    always_comb
    begin
        if (p_single_reg)
            total = 5'd1;
        else
            total = (p_prev_reg ? 5'd8 : 5'd0) +
                    (p_tail_reg ? {2'd0, p_k_reg} + 5'd1 : 5'd0);

        t_idx = drain_idx_reg[2:0];
        rd_idx = {p_pb_reg[0], t_idx};
        e_pos = '0;
        e_addr = '0;
        e_len = '0;
        e_kind = csgl_pkg::KIND_END;
        e_status = csgl_pkg::ST_OK;
        e_lor = 1'b1;
        if (p_single_reg)
        begin
            e_kind = p_skind_reg;
            e_status = p_sstatus_reg;
        end
        else if (p_prev_reg && !drain_idx_reg[3])
        begin
            rd_idx = {p_pb_reg[0], t_idx};
            e_pos = {p_pb_reg[13:0], t_idx};
            e_addr = held_addr[rd_idx];
            e_len = held_len[rd_idx];
            e_kind = held_kind[rd_idx];
            e_lor = 1'b0;
        end
        else if (t_idx < p_k_reg)
        begin
            rd_idx = {p_tb_reg[0], t_idx + 3'd1};
            e_pos = {p_tb_reg[13:0], t_idx};
            e_addr = held_addr[rd_idx];
            e_len = held_len[rd_idx];
            e_kind = held_kind[rd_idx];
            e_lor = 1'b0;
        end
        else
        begin
            e_pos = {p_tb_reg[13:0], p_k_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_offset_reg <= '0;
            total_bytes_reg <= '0;
            page_count_reg <= 16'd1;
            list_base_reg <= '0;
            list_bytes_reg <= '0;
            pages_taken_reg <= '0;
            slot_in_block_reg <= '0;
            blocks_done_reg <= '0;
            bytes_left_reg <= '0;
            next_contig_reg <= '0;
            have_fragment_reg <= 1'b0;
            error_latched_reg <= 1'b0;
            p_single_reg <= 1'b0;
            p_prev_reg <= 1'b0;
            p_tail_reg <= 1'b0;
            drain_idx_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            if (cfg_hit)
            begin
                case (paddr[5:3])
                    csgl_pkg::REG_FIRST_OFFSET: first_offset_reg <= pwdata[13:0];
                    csgl_pkg::REG_TOTAL_BYTES:  total_bytes_reg <= pwdata[31:0];
                    csgl_pkg::REG_PAGE_COUNT:   page_count_reg <= pwdata[15:0];
                    csgl_pkg::REG_LIST_BASE:    list_base_reg <= pwdata;
                    csgl_pkg::REG_LIST_BYTES:   list_bytes_reg <= pwdata[31:0];
                    default:                    list_bytes_reg <= list_bytes_reg;
                endcase
                pages_taken_reg <= '0;
                slot_in_block_reg <= '0;
                blocks_done_reg <= '0;
                bytes_left_reg <= '0;
                next_contig_reg <= '0;
                have_fragment_reg <= 1'b0;
                error_latched_reg <= 1'b0;
            end
            else if (cmd.proc && !error_latched_reg)
            begin
                p_single_reg <= off_err || small_err || zero_pc;
                p_prev_reg <= run && prev;
                p_tail_reg <= run && is_last;
                drain_idx_reg <= '0;
                if (off_err || small_err)
                    error_latched_reg <= 1'b1;
                if (run)
                begin
                    if (is_last)
                    begin
                        pages_taken_reg <= '0;
                        slot_in_block_reg <= '0;
                        blocks_done_reg <= '0;
                        bytes_left_reg <= '0;
                        next_contig_reg <= '0;
                        have_fragment_reg <= 1'b0;
                    end
                    else
                    begin
                        pages_taken_reg <= pages_next;
                        slot_in_block_reg <= slot_next;
                        blocks_done_reg <= bd_next;
                        bytes_left_reg <= bl_e - size;
                        next_contig_reg <= daddr + {32'd0, size};
                        have_fragment_reg <= 1'b1;
                    end
                end
            end
            else if (cmd.load)
            begin
                drain_idx_reg <= drain_idx_reg + 4'd1;
                out_last_reg <= ({1'b0, drain_idx_reg} == total - 5'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
            page_reg <= page_addr;
        if (cmd.proc && !error_latched_reg)
        begin
            p_skind_reg <= zero_pc ? csgl_pkg::KIND_END : csgl_pkg::KIND_CHAIN;
            p_sstatus_reg <= off_err ? csgl_pkg::ST_OFFSET :
                             (small_err ? csgl_pkg::ST_SMALL : csgl_pkg::ST_OK);
            p_pb_reg <= bd_next - 16'd1;
            p_tb_reg <= tb_next;
            p_k_reg <= k_next;
            if (run)
            begin
                if (need_chain)
                begin
                    held_addr[{bd_next[0], 3'd0}] <= chain_addr;
                    held_len[{bd_next[0], 3'd0}] <= 32'(csgl_pkg::CHAIN_LEN);
                    held_kind[{bd_next[0], 3'd0}] <= csgl_pkg::KIND_CHAIN;
                end
                if (merge)
                begin
                    held_len[merge_idx] <= cur_len_reg + size;
                    cur_len_reg <= cur_len_reg + size;
                end
                else
                begin
                    held_addr[{bd_next[0], slot_c[2:0]}] <= daddr;
                    held_len[{bd_next[0], slot_c[2:0]}] <= size;
                    held_kind[{bd_next[0], slot_c[2:0]}] <= csgl_pkg::KIND_DATA;
                    cur_len_reg <= size;
                end
            end
        end
        if (cmd.load)
        begin
            pos_reg <= e_pos;
            addr_reg <= e_addr;
            len_reg <= e_len;
            kind_reg <= e_kind;
            status_reg <= e_status;
            lor_reg <= e_lor;
        end
    end

    assign entry_pos = pos_reg;
    assign entry_addr = addr_reg;
    assign entry_len = len_reg;
    assign entry_kind = kind_reg;
    assign status = status_reg;
    assign last_of_run = lor_reg;

endmodule

>>> sv/csgl_controller.sv
// csgl_controller: handshake sequencer for page intake, step processing and entry drain
// depends on csgl_pkg
module csgl_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  csgl_pkg::stat_t stat,
    output csgl_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PROC = 4'b0010,
        S_LOAD = 4'b0100,
        S_SHOW = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_PROC;
            end
            S_PROC:
            begin
                state_next = stat.has_results ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                state_next = S_SHOW;
            end
            S_SHOW:
            begin
                if (out_ready && stat.drain_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_SHOW);
    assign cmd.take = in_valid && in_ready;
    assign cmd.proc = (state_reg == S_PROC);
    assign cmd.load = (state_reg == S_LOAD) ||
                      ((state_reg == S_SHOW) && out_ready && !stat.drain_last);

`ifndef NO_ASSERTIONS
    a_take_then_proc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_PROC))
        else $error("accepted page not processed next cycle");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("intake open while an entry is shown");

    a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && stat.drain_last) |=> in_ready)
        else $error("controller did not return to idle after last entry");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |=> out_valid)
        else $error("loaded entry not shown");
`endif

endmodule
